[rtl/core/tcs_pkg.sv]
// Shared types, constants and byte classification for the text statistics block.
`default_nettype none
package tcs_pkg;

  localparam int NUM_BINS  = 95;
  localparam int BIN_AW    = 7;
  localparam int OUT_W     = 32;
  localparam int OQ_DEPTH  = 3;

  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd126;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] LOWER_A    = 8'd97;
  localparam logic [7:0] LOWER_Z    = 8'd122;
  localparam logic [7:0] UPPER_A    = 8'd65;
  localparam logic [7:0] UPPER_Z    = 8'd90;
  localparam logic [7:0] DIGIT_0    = 8'd48;
  localparam logic [7:0] DIGIT_9    = 8'd57;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } tcs_cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] word_count;
    logic [OUT_W-1:0] space_count;
    logic [OUT_W-1:0] char_count;
    logic [OUT_W-1:0] letter_count;
    logic [OUT_W-1:0] lower_count;
    logic [OUT_W-1:0] upper_count;
    logic [OUT_W-1:0] digit_count;
    logic [OUT_W-1:0] special_count;
  } tcs_result_t;

  typedef struct packed {
    logic              en;
    logic              clr;
    logic [BIN_AW-1:0] addr;
  } tcs_mem_ctl_t;

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= CHAR_FIRST) && (b <= CHAR_LAST);
  endfunction

  // backslash and ampersand are word bytes
  function automatic logic is_delim(input logic [7:0] b);
    return b inside {[8'h20:8'h25], [8'h27:8'h2F], [8'h3A:8'h40], 8'h5B, [8'h5D:8'h60],
                     [8'h7B:8'h7E], 8'h0A};
  endfunction

endpackage
`default_nettype wire

[rtl/core/tcs_chan_if.sv]
// Request and response channel interfaces of the text statistics block.
`default_nettype none
interface tcs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] text_byte;
  logic [6:0] bin_index;

  modport source (output valid, command, text_byte, bin_index, input ready);
  modport sink   (input valid, command, text_byte, bin_index, output ready);
endinterface

interface tcs_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] bin_count;
  logic [31:0] word_count;
  logic [31:0] space_count;
  logic [31:0] char_count;
  logic [31:0] letter_count;
  logic [31:0] lower_count;
  logic [31:0] upper_count;
  logic [31:0] digit_count;
  logic [31:0] special_count;

  modport source (output valid, bin_count, word_count, space_count, char_count,
                  letter_count, lower_count, upper_count, digit_count, special_count,
                  input ready);
  modport sink   (input valid, bin_count, word_count, space_count, char_count,
                  letter_count, lower_count, upper_count, digit_count, special_count,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/text_character_statistics.sv]
// Top level of the text character statistics block.
// Takes one request word per cycle. The histogram bin is read from memory at the
// accepting edge, updated in the next cycle with forwarding of the previous cycle's
// write (or clear), and the result enters a three-word queue: it passes the update
// stage register and then the queue before the response channel offers it.
// Throughput is one word per cycle while the response side keeps up; it is set
// by the single read-modify-write of the histogram memory. The request side stalls
// while the queue and the update stage hold three words. Counters saturate at
// 2^COUNT_BITS-1 and report their low 32 bits.
`default_nettype none
module text_character_statistics #(
  parameter int COUNT_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  tcs_req_if.sink   req,
  tcs_rsp_if.source rsp
);
  import tcs_pkg::*;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_ONE = COUNT_BITS'(1);

  function automatic cnt_t sat_inc(input cnt_t c);
    return (&c) ? c : c + CNT_ONE;
  endfunction

  function automatic logic [OUT_W-1:0] to_word(input cnt_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[OUT_W-1:0];
  endfunction

  // request side
  logic              in_acc;
  logic [BIN_AW-1:0] rd_addr;
  logic              rd_sel;
  logic [1:0]        q_count;

  // execute stage
  logic              s1_valid;
  logic [1:0]        s1_cmd;
  logic [7:0]        s1_byte;
  logic [BIN_AW-1:0] s1_addr;
  logic              s1_hit;

  // forwarding of the write done at the previous edge
  logic              fwd_valid;
  logic              fwd_clr;
  logic [BIN_AW-1:0] fwd_addr;
  cnt_t              fwd_data;

  cnt_t         rd_data;
  logic         rd_hit;
  cnt_t         cur_bin;
  cnt_t         new_bin;
  cnt_t         res_bin;
  tcs_mem_ctl_t wr_ctl;
  tcs_result_t  result;

  cnt_t words_seen, words_seen_next;
  cnt_t chars_seen, chars_seen_next;
  cnt_t lower_seen, lower_seen_next;
  cnt_t upper_seen, upper_seen_next;
  cnt_t letters_seen, letters_seen_next;
  cnt_t digits_seen, digits_seen_next;
  cnt_t specials_seen, specials_seen_next;
  cnt_t spaces_seen, spaces_seen_next;
  logic inside_word, inside_word_next;
  logic text_ended, text_ended_next;

  assign req.ready = (3'(q_count) + 3'(s1_valid)) <= 3'd2;
  assign in_acc    = req.valid && req.ready;

  always_comb begin
    rd_addr = '0;
    rd_sel  = 1'b0;
    case (req.command)
      CMD_PUSH: begin
        rd_sel = is_printable(req.text_byte);
        if (rd_sel) begin
          rd_addr = BIN_AW'(req.text_byte - CHAR_FIRST);
        end
      end
      CMD_CLEAR: begin
        rd_sel = 1'b0;
      end
      default: begin
        rd_sel = (req.bin_index < BIN_AW'(NUM_BINS));
        if (rd_sel) begin
          rd_addr = req.bin_index;
        end
      end
    endcase
  end

  tcs_hist_mem #(
    .COUNT_BITS(COUNT_BITS)
  ) u_hist_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rd_hit  (rd_hit),
    .wr_ctl  (wr_ctl),
    .wr_data (new_bin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      fwd_clr   <= 1'b0;
    end else begin
      s1_valid  <= in_acc;
      fwd_valid <= wr_ctl.en;
      fwd_clr   <= wr_ctl.clr;
    end
    if (in_acc) begin
      s1_cmd  <= req.command;
      s1_byte <= req.text_byte;
      s1_addr <= rd_addr;
      s1_hit  <= rd_sel;
    end
    fwd_addr <= wr_ctl.addr;
    fwd_data <= new_bin;
  end

  always_comb begin
    if (fwd_clr) begin
      cur_bin = '0;
    end else if (fwd_valid && (fwd_addr == s1_addr)) begin
      cur_bin = fwd_data;
    end else if (rd_hit) begin
      cur_bin = rd_data;
    end else begin
      cur_bin = '0;
    end
  end

  always_comb begin
    words_seen_next    = words_seen;
    chars_seen_next    = chars_seen;
    lower_seen_next    = lower_seen;
    upper_seen_next    = upper_seen;
    letters_seen_next  = letters_seen;
    digits_seen_next   = digits_seen;
    specials_seen_next = specials_seen;
    spaces_seen_next   = spaces_seen;
    inside_word_next   = inside_word;
    text_ended_next    = text_ended;
    new_bin            = sat_inc(cur_bin);
    res_bin            = s1_hit ? cur_bin : '0;
    wr_ctl             = '{en: 1'b0, clr: 1'b0, addr: s1_addr};
    if (s1_valid) begin
      case (s1_cmd)
        CMD_PUSH: begin
          if (!text_ended) begin
            if (s1_byte == CHAR_NUL) begin
              text_ended_next = 1'b1;
            end else begin
              chars_seen_next = sat_inc(chars_seen);
              if (is_delim(s1_byte)) begin
                inside_word_next = 1'b0;
              end else if (!inside_word) begin
                inside_word_next = 1'b1;
                words_seen_next  = sat_inc(words_seen);
              end
              if (s1_hit) begin
                wr_ctl.en = 1'b1;
                res_bin   = new_bin;
                if (s1_byte >= LOWER_A && s1_byte <= LOWER_Z) begin
                  lower_seen_next   = sat_inc(lower_seen);
                  letters_seen_next = sat_inc(letters_seen);
                end else if (s1_byte >= DIGIT_0 && s1_byte <= DIGIT_9) begin
                  digits_seen_next = sat_inc(digits_seen);
                end else if (s1_byte >= UPPER_A && s1_byte <= UPPER_Z) begin
                  upper_seen_next   = sat_inc(upper_seen);
                  letters_seen_next = sat_inc(letters_seen);
                end else if (s1_byte == CHAR_SPACE) begin
                  spaces_seen_next = sat_inc(spaces_seen);
                end else begin
                  specials_seen_next = sat_inc(specials_seen);
                end
              end
            end
          end
        end
        CMD_CLEAR: begin
          wr_ctl.clr         = 1'b1;
          res_bin            = '0;
          words_seen_next    = '0;
          chars_seen_next    = '0;
          lower_seen_next    = '0;
          upper_seen_next    = '0;
          letters_seen_next  = '0;
          digits_seen_next   = '0;
          specials_seen_next = '0;
          spaces_seen_next   = '0;
          inside_word_next   = 1'b0;
          text_ended_next    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_seen    <= '0;
      chars_seen    <= '0;
      lower_seen    <= '0;
      upper_seen    <= '0;
      letters_seen  <= '0;
      digits_seen   <= '0;
      specials_seen <= '0;
      spaces_seen   <= '0;
      inside_word   <= 1'b0;
      text_ended    <= 1'b0;
    end else begin
      words_seen    <= words_seen_next;
      chars_seen    <= chars_seen_next;
      lower_seen    <= lower_seen_next;
      upper_seen    <= upper_seen_next;
      letters_seen  <= letters_seen_next;
      digits_seen   <= digits_seen_next;
      specials_seen <= specials_seen_next;
      spaces_seen   <= spaces_seen_next;
      inside_word   <= inside_word_next;
      text_ended    <= text_ended_next;
    end
  end

  always_comb begin
    result.bin_count     = to_word(res_bin);
    result.word_count    = to_word(words_seen_next);
    result.space_count   = to_word(spaces_seen_next);
    result.char_count    = to_word(chars_seen_next);
    result.letter_count  = to_word(letters_seen_next);
    result.lower_count   = to_word(lower_seen_next);
    result.upper_count   = to_word(upper_seen_next);
    result.digit_count   = to_word(digits_seen_next);
    result.special_count = to_word(specials_seen_next);
  end

  tcs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (result),
    .count     (q_count),
    .rsp       (rsp)
  );

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (q_count != 2'd3))
    else $error("result queue overflow");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_cmd == CMD_CLEAR) |=>
      (chars_seen == '0 && words_seen == '0 && !text_ended && fwd_clr))
    else $error("clear did not zero the counters");

  a_letters_bound: assert property (@(posedge clk) disable iff (rst)
    (letters_seen >= lower_seen) && (letters_seen >= upper_seen))
    else $error("letter count below a class count");

  a_ended_frozen: assert property (@(posedge clk) disable iff (rst)
    (text_ended && !(s1_valid && s1_cmd == CMD_CLEAR)) |=>
      ($stable(chars_seen) && $stable(words_seen) && !fwd_valid))
    else $error("counts moved after end of text");

endmodule
`default_nettype wire

[rtl/core/tcs_hist_mem.sv]
// Histogram memory: one write port, one registered read port, per-entry valid bits.
`default_nettype none
module tcs_hist_mem #(
  parameter int COUNT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tcs_pkg::BIN_AW-1:0] rd_addr,
  output logic [COUNT_BITS-1:0]     rd_data,
  output logic                      rd_hit,
  input  tcs_pkg::tcs_mem_ctl_t     wr_ctl,
  input  logic [COUNT_BITS-1:0]     wr_data
);
  import tcs_pkg::*;

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]   valid;

  always_ff @(posedge clk) begin
    if (wr_ctl.en) begin
      mem[wr_ctl.addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || wr_ctl.clr) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_ctl.en) begin
        valid[wr_ctl.addr] <= 1'b1;
      end
      rd_hit <= valid[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/tcs_out_fifo.sv]
// Three-word result queue in front of the response channel.
`default_nettype none
module tcs_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tcs_pkg::tcs_result_t push_data,
  output logic [1:0]          count,
  tcs_rsp_if.source           rsp
);
  import tcs_pkg::*;

  localparam logic [1:0] LAST_PTR = 2'(OQ_DEPTH - 1);

  tcs_result_t entries [OQ_DEPTH];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic        pop;
  tcs_result_t head;

  assign pop  = rsp.valid && rsp.ready;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? 2'd0 : rd_ptr + 2'd1;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign rsp.valid         = (count != 2'd0);
  assign rsp.bin_count     = head.bin_count;
  assign rsp.word_count    = head.word_count;
  assign rsp.space_count   = head.space_count;
  assign rsp.char_count    = head.char_count;
  assign rsp.letter_count  = head.letter_count;
  assign rsp.lower_count   = head.lower_count;
  assign rsp.upper_count   = head.upper_count;
  assign rsp.digit_count   = head.digit_count;
  assign rsp.special_count = head.special_count;

endmodule
`default_nettype wire
